// ----- sv/ahle_pkg.sv -----
// Shared types and constants of the AX.25 HDLC line encoder.
package ahle_pkg;

   // HDLC framing and FCS constants.
   localparam logic [7:0]  HDLC_FLAG = 8'h7E;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [2:0]  STUFF_RUN_LAST = 3'd4;  // a one after four ones ends a run of five
   localparam logic [4:0]  DATA_CAP  = 5'd25;      // most line bytes sent per request

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_LINE_MODE     = 2'd0;
   localparam logic [1:0] REG_OPENING_FLAGS = 2'd1;
   localparam logic [1:0] REG_CLOSING_FLAGS = 2'd2;
   localparam logic [1:0] REG_OUTPUT_LIMIT  = 2'd3;

   // Request payload.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       final_byte;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic [7:0]  line_byte;
      logic        byte_valid;
      logic        frame_end;
      logic        overflowed;
      logic [15:0] frame_length;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic        line_mode;
      logic [4:0]  opening_flags;
      logic [4:0]  closing_flags;
      logic [15:0] output_limit;
   } cfg_type;

   // Command from the bit sequencer to the line coder and packer.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_BIT,
      OP_FLUSH,
      OP_END
   } op_type;

   typedef struct packed {
      op_type op;
      logic   line_bit;
      logic   frame_start;
      logic   step_start;
   } cmd_type;

endpackage

// ----- sv/ahle_csr.sv -----
// Configuration register file behind the APB-style port.
module ahle_csr
   import ahle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_LINE_MODE:     cfg_in.line_mode     = pwdata[0];
            REG_OPENING_FLAGS: cfg_in.opening_flags = pwdata[4:0];
            REG_CLOSING_FLAGS: cfg_in.closing_flags = pwdata[4:0];
            REG_OUTPUT_LIMIT:  cfg_in.output_limit  = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_mode     <= 1'b0;
         cfg_ff.opening_flags <= 5'd1;
         cfg_ff.closing_flags <= 5'd1;
         cfg_ff.output_limit  <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read decode.
   always_comb begin
      unique case (paddr[3:2])
         REG_LINE_MODE:     prdata = {31'd0, cfg_ff.line_mode};
         REG_OPENING_FLAGS: prdata = {27'd0, cfg_ff.opening_flags};
         REG_CLOSING_FLAGS: prdata = {27'd0, cfg_ff.closing_flags};
         REG_OUTPUT_LIMIT:  prdata = {16'd0, cfg_ff.output_limit};
         default:           prdata = 32'd0;
      endcase
   end

endmodule

// ----- sv/ahle_bit_seq.sv -----
// Bit sequencer: flags, stuffed body and FCS bits, one per cycle unless adv holds it, with the CRC.
module ahle_bit_seq
   import ahle_pkg::*;
#(
   parameter int MAX_FLAGS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  req_type req_payload,
   input  cfg_type cfg,
   input  logic    adv,
   output logic    busy,
   output cmd_type cmd
);

   localparam int FLAG_W = $clog2(MAX_FLAGS + 1);
   localparam logic [4:0] DATA_BITS = 5'd8;
   localparam logic [4:0] FCS_BITS  = 5'd16;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN,
      S_DATA,
      S_FCS,
      S_CLOSE,
      S_FLUSH,
      S_END
   } state_type;

   state_type         state_ff, state_in;
   logic [15:0]       shift_ff, shift_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              stuff_ff, stuff_in;
   logic [2:0]        ones_ff, ones_in;
   logic [15:0]       crc_ff, crc_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [2:0]        fbit_ff, fbit_in;
   logic              final_ff, final_in;
   logic              in_frame_ff, in_frame_in;
   cmd_type           cmd_in;

   logic [4:0]        lim;
   logic              body_bit;
   logic              body_done;
   logic [FLAG_W-1:0] open_cnt, close_cnt;

   // Clamp a flag count to the largest supported count.
   function automatic logic [FLAG_W-1:0] flag_sat(input logic [4:0] n);
      if (int'(n) > MAX_FLAGS) begin
         return FLAG_W'(MAX_FLAGS);
      end else begin
         return FLAG_W'(n);
      end
   endfunction

   assign open_cnt  = flag_sat(cfg.opening_flags);
   assign close_cnt = flag_sat(cfg.closing_flags);
   assign lim       = (state_ff == S_FCS) ? FCS_BITS : DATA_BITS;
   assign busy      = (state_ff != S_IDLE);
   assign cmd       = cmd_in;

   // Next-state and bit selection.
   always_comb begin
      state_in    = state_ff;
      shift_in    = shift_ff;
      cnt_in      = cnt_ff;
      stuff_in    = stuff_ff;
      ones_in     = ones_ff;
      crc_in      = crc_ff;
      flags_in    = flags_ff;
      fbit_in     = fbit_ff;
      final_in    = final_ff;
      in_frame_in = in_frame_ff;
      cmd_in      = '{op: OP_NONE, line_bit: 1'b0, frame_start: 1'b0, step_start: 1'b0};
      body_bit    = shift_ff[0];
      body_done   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               shift_in          = {8'd0, req_payload.frame_byte};
               final_in          = req_payload.final_byte;
               cnt_in            = 5'd0;
               stuff_in          = 1'b0;
               cmd_in.step_start = 1'b1;
               state_in          = S_DATA;
               if (!in_frame_ff) begin
                  cmd_in.frame_start = 1'b1;
                  in_frame_in        = 1'b1;
                  ones_in            = 3'd0;
                  crc_in             = CRC_INIT;
                  flags_in           = open_cnt;
                  fbit_in            = 3'd0;
                  if (open_cnt != '0) begin
                     state_in = S_OPEN;
                  end
               end
            end
         end

         S_OPEN, S_CLOSE: begin
            if (adv) begin
               cmd_in.op       = OP_BIT;
               cmd_in.line_bit = HDLC_FLAG[fbit_ff];
               fbit_in         = fbit_ff + 3'd1;
               if (fbit_ff == 3'd7) begin
                  flags_in = flags_ff - FLAG_W'(1);
                  if (flags_ff == FLAG_W'(1)) begin
                     state_in = (state_ff == S_OPEN) ? S_DATA : S_FLUSH;
                  end
               end
            end
         end

         S_DATA, S_FCS: begin
            if (adv) begin
               cmd_in.op = OP_BIT;
               if (stuff_ff) begin
                  // Stuffed zero after a run of five ones.
                  cmd_in.line_bit = 1'b0;
                  stuff_in        = 1'b0;
                  ones_in         = 3'd0;
                  body_done       = (cnt_ff == lim);
               end else begin
                  cmd_in.line_bit = body_bit;
                  shift_in        = {1'b0, shift_ff[15:1]};
                  cnt_in          = cnt_ff + 5'd1;
                  if (state_ff == S_DATA) begin
                     if (crc_ff[0] ^ body_bit) begin
                        crc_in = {1'b0, crc_ff[15:1]} ^ CRC_POLY;
                     end else begin
                        crc_in = {1'b0, crc_ff[15:1]};
                     end
                  end
                  if (body_bit) begin
                     ones_in = ones_ff + 3'd1;
                     if (ones_ff == STUFF_RUN_LAST) begin
                        stuff_in = 1'b1;
                     end
                  end else begin
                     ones_in = 3'd0;
                  end
                  body_done = (cnt_ff == lim - 5'd1) &&
                              !(body_bit && (ones_ff == STUFF_RUN_LAST));
               end

               // End of a body byte or of the FCS.
               if (body_done) begin
                  if (state_ff == S_DATA) begin
                     if (final_ff) begin
                        shift_in = ~crc_in;
                        cnt_in   = 5'd0;
                        state_in = S_FCS;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     flags_in = close_cnt;
                     fbit_in  = 3'd0;
                     state_in = (close_cnt != '0) ? S_CLOSE : S_FLUSH;
                  end
               end
            end
         end

         S_FLUSH: begin
            if (adv) begin
               cmd_in.op = OP_FLUSH;
               state_in  = S_END;
            end
         end

         S_END: begin
            if (adv) begin
               cmd_in.op   = OP_END;
               in_frame_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         in_frame_ff <= 1'b0;
         stuff_ff    <= 1'b0;
         ones_ff     <= 3'd0;
         cnt_ff      <= 5'd0;
         fbit_ff     <= 3'd0;
         flags_ff    <= '0;
         crc_ff      <= CRC_INIT;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         stuff_ff    <= stuff_in;
         ones_ff     <= ones_in;
         cnt_ff      <= cnt_in;
         fbit_ff     <= fbit_in;
         flags_ff    <= flags_in;
         crc_ff      <= crc_in;
      end
      shift_ff <= shift_in;
      final_ff <= final_in;
   end

endmodule

// ----- sv/ahle_line_pack.sv -----
// Line coder (NRZI or G3RUH scrambler), byte packer and output limit.
module ahle_line_pack
   import ahle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  cfg_type cfg,
   output logic    emit,
   output rsp_type result
);

   logic        nrzi_ff, nrzi_in;
   logic [16:0] scr_ff, scr_in;
   logic [7:0]  pack_ff, pack_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] bytes_ff, bytes_in;
   logic        over_ff, over_in;
   logic [4:0]  step_ff, step_in;

   logic        lv;
   logic [7:0]  pack_nxt;
   logic        flush_req;
   logic [7:0]  flush_byte;

   // Coding, packing and result generation for one command.
   always_comb begin
      nrzi_in    = nrzi_ff;
      scr_in     = scr_ff;
      pack_in    = pack_ff;
      pos_in     = pos_ff;
      bytes_in   = bytes_ff;
      over_in    = over_ff;
      step_in    = step_ff;
      lv         = 1'b0;
      pack_nxt   = pack_ff;
      flush_req  = 1'b0;
      flush_byte = pack_ff;
      emit       = 1'b0;
      result     = '0;

      if (cmd.frame_start) begin
         nrzi_in  = 1'b0;
         scr_in   = '0;
         pack_in  = '0;
         pos_in   = '0;
         bytes_in = '0;
         over_in  = 1'b0;
      end
      if (cmd.step_start) begin
         step_in = '0;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end

         OP_BIT: begin
            // The scrambler runs on every bit, even once output is dropped.
            if (cfg.line_mode) begin
               lv     = cmd.line_bit ^ scr_ff[11] ^ scr_ff[16];
               scr_in = {scr_ff[15:0], lv};
            end
            if (!over_ff) begin
               if (bytes_ff >= cfg.output_limit) begin
                  over_in = 1'b1;
               end else begin
                  if (!cfg.line_mode) begin
                     nrzi_in = nrzi_ff ^ ~cmd.line_bit;
                     lv      = nrzi_in;
                  end
                  pack_nxt              = pack_ff;
                  pack_nxt[3'd7 - pos_ff] = lv;
                  if (pos_ff == 3'd7) begin
                     flush_req  = 1'b1;
                     flush_byte = pack_nxt;
                  end else begin
                     pack_in = pack_nxt;
                     pos_in  = pos_ff + 3'd1;
                  end
               end
            end
         end

         OP_FLUSH: begin
            // Send a partly filled last byte, zero padded.
            if ((pos_ff != 3'd0) && !over_ff) begin
               flush_req  = 1'b1;
               flush_byte = pack_ff;
            end
            pack_in = '0;
            pos_in  = '0;
         end

         OP_END: begin
            emit                = 1'b1;
            result.frame_end    = 1'b1;
            result.overflowed   = over_ff;
            result.frame_length = over_ff ? 16'd0 : bytes_ff;
         end
      endcase

      // A full or flushed partial byte goes out unless this request already sent its share.
      if (flush_req) begin
         if (step_ff < DATA_CAP) begin
            emit              = 1'b1;
            result.line_byte  = flush_byte;
            result.byte_valid = 1'b1;
            bytes_in          = bytes_ff + 16'd1;
            step_in           = step_ff + 5'd1;
         end else begin
            over_in = 1'b1;
         end
         pack_in = '0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrzi_ff  <= 1'b0;
         scr_ff   <= '0;
         pack_ff  <= '0;
         pos_ff   <= '0;
         bytes_ff <= '0;
         over_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         nrzi_ff  <= nrzi_in;
         scr_ff   <= scr_in;
         pack_ff  <= pack_in;
         pos_ff   <= pos_in;
         bytes_ff <= bytes_in;
         over_ff  <= over_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- sv/ax25_hdlc_line_encoder_top.sv -----
// Top level of the AX.25 HDLC line encoder.
//
//   Channel  Direction  Handshake                 Payload
//   req      in         req_valid / req_stall     req_payload (frame_byte, final_byte)
//   rsp      out        rsp_valid / rsp_stall     rsp_payload (line_byte ... frame_length)
//   csr      in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One line bit leaves the bit sequencer per cycle unless the result register
// holds it. A body byte is accepted, then sent as its stuffed bits. The first
// byte of a frame adds the opening flags; the final byte adds the FCS bits, the
// closing flags, a flush of the last partial byte and the end item.
// Reset is synchronous and returns the registers to their defaults and the
// encoder to idle. While the result register is full and rsp_stall is high, the
// sequencer holds; a new request is taken whenever the sequencer is idle.
module ax25_hdlc_line_encoder_top
   import ahle_pkg::*;
#(
   parameter int MAX_FLAGS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type cfg;
   cmd_type cmd;
   logic    busy;
   logic    adv;
   logic    req_accept;
   logic    emit;
   rsp_type result;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign adv        = !rsp_valid_ff || !rsp_stall;

   ahle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ahle_bit_seq #(
      .MAX_FLAGS (MAX_FLAGS)
   ) u_bit_seq (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .cfg         (cfg),
      .adv         (adv),
      .busy        (busy),
      .cmd         (cmd)
   );

   ahle_line_pack u_line_pack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   // Result register between the packer and the result channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
